// ===== design/per_client_fixed_window_limiter_assert.svh =====
// Assertion macros used by the checker file of the limiter.
`ifndef PER_CLIENT_FIXED_WINDOW_LIMITER_ASSERT_SVH
`define PER_CLIENT_FIXED_WINDOW_LIMITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCFWL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcfwl assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCFWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcfwl assertion failed");

// Consequent must hold in the cycle after the antecedent, reset included.
`define PCFWL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pcfwl assertion failed");

`endif

// ===== design/pcfwl_pkg.sv =====
// Package of the per-client fixed window limiter: sizes, types, codes and the slot mapping.
`default_nettype none
package pcfwl_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CLIENT_W    = 12;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS   = 1'd1;

    localparam logic [TIME_W-1:0] WINDOW_TICKS_RESET = 32'd60000;

    typedef struct packed {
        logic               used;
        logic [TIME_W-1:0]  win_begin;
        logic [COUNT_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] addr;
    } t_sweep;

    // Reduce a client index modulo the table depth by constant compare-and-subtract.
    function automatic logic [IDX_W-1:0] slot_of(input logic [CLIENT_W-1:0] x);
        logic [CLIENT_W-1:0] rem;
        rem = x;
        if (TABLE_DEPTH < (1 << CLIENT_W)) begin
            for (int k = CLIENT_W - 1; k >= 0; k--) begin
                if ((TABLE_DEPTH << k) < (1 << CLIENT_W)) begin
                    if (int'(rem) >= (TABLE_DEPTH << k)) begin
                        rem = rem - CLIENT_W'(TABLE_DEPTH << k);
                    end
                end
            end
        end
        return IDX_W'(rem);
    endfunction

endpackage
`default_nettype wire

// ===== design/pcfwl_req_if.sv =====
// Request channel interface: client index and current time.
`default_nettype none
interface pcfwl_req_if
    import pcfwl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CLIENT_W-1:0] client_index;
    logic [TIME_W-1:0]   now_time;

    modport source (output valid, output client_index, output now_time, input ready);
    modport sink   (input valid, input client_index, input now_time, output ready);
endinterface
`default_nettype wire

// ===== design/pcfwl_rsp_if.sv =====
// Response channel interface: allow or deny answer.
`default_nettype none
interface pcfwl_rsp_if;
    logic valid;
    logic ready;
    logic allowed;

    modport source (output valid, output allowed, input ready);
    modport sink   (input valid, input allowed, output ready);
endinterface
`default_nettype wire

// ===== design/pcfwl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module pcfwl_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 49,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read returns the old contents on a same-address write; hold when not read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== design/pcfwl_sweep.sv =====
// Clearing sequencer: walks every table entry once after reset and after a limit write.
`default_nettype none
module pcfwl_sweep
    import pcfwl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output t_sweep    o_sweep
);
    logic             r_busy;
    logic [IDX_W-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            if (r_addr == IDX_W'(TABLE_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end
    end

    assign o_sweep.busy = r_busy;
    assign o_sweep.addr = r_addr;
endmodule
`default_nettype wire

// ===== design/per_client_fixed_window_limiter.sv =====
// Top level of the per-client fixed window rate limiter.
//
// Usage:
//   i_req carries one request item: client_index and now_time. o_rsp returns one
//   item per request, allowed = 1 to pass it and 0 to drop it, in request order.
//   Both channels hand over an item when valid and ready are high at a clock edge.
//   i_cfg_we/i_cfg_index/i_cfg_data write max_per_window (index 0) and
//   window_ticks (index 1); write them only while no request is in flight.
// Timing:
//   An accepted request reads the table RAM into the decision stage, which writes
//   the entry back and registers the answer in the output register for o_rsp.
//   A request for the client just written takes the new entry from a forwarding
//   register. One request per cycle is taken unless o_rsp stalls or a sweep runs.
// Reset and clearing:
//   After reset, and after every write of max_per_window, a sweep clears the
//   used mark of every entry, one entry per cycle; i_req.ready stays low for the
//   sweep. Configuration writes are taken anyway.
// Stall:
//   When o_rsp is stalled, the answer holds in the output register, one more
//   request is taken and held at the RAM output, then i_req.ready drops.
`default_nettype none
module per_client_fixed_window_limiter
    import pcfwl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    pcfwl_req_if.sink                  i_req,
    pcfwl_rsp_if.source                o_rsp
);
    // Configuration registers.
    logic [COUNT_W-1:0] r_max;
    logic [TIME_W-1:0]  r_window;

    // Decision stage: the request whose entry is arriving from the RAM.
    logic               r_b_valid;
    logic [IDX_W-1:0]   r_b_slot;
    logic [TIME_W-1:0]  r_b_now;
    logic               r_fwd_hit;
    t_entry             r_fwd_data;

    // Output register.
    logic               r_out_valid;
    logic               r_out_allowed;

    t_sweep             w_sweep;
    logic               w_limit_write;
    logic               w_b_go;
    logic               w_ready;
    logic               w_accept;
    logic [IDX_W-1:0]   w_in_slot;
    logic [ENTRY_W-1:0] w_rd_raw;
    t_entry             w_ent;
    t_entry             w_new;
    logic               w_restart;
    logic [COUNT_W-1:0] w_cnt;
    logic               w_deny;
    logic               w_allowed;
    logic               w_upd;
    logic               w_mem_we;
    logic [IDX_W-1:0]   w_mem_waddr;
    logic [ENTRY_W-1:0] w_mem_wdata;

    assign w_limit_write = i_cfg_we && (i_cfg_index == CFG_MAX_PER_WINDOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= '0;
            r_window <= WINDOW_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_PER_WINDOW: r_max    <= i_cfg_data[COUNT_W-1:0];
                CFG_WINDOW_TICKS:   r_window <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    pcfwl_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_limit_write),
        .o_sweep (w_sweep)
    );

    // Advance the decision stage when the output register is free or being taken.
    assign w_b_go    = r_b_valid && (!r_out_valid || o_rsp.ready);
    assign w_ready   = !w_sweep.busy && (!r_b_valid || w_b_go);
    assign w_accept  = i_req.valid && w_ready;
    assign w_in_slot = slot_of(i_req.client_index);

    // Pick the freshest copy of the entry: forwarded write or RAM data.
    assign w_ent = r_fwd_hit ? r_fwd_data : t_entry'(w_rd_raw);

    always_comb begin
        w_restart = !w_ent.used || ((r_b_now - w_ent.win_begin) >= r_window);
        w_cnt     = w_restart ? '0 : w_ent.count;
        w_deny    = (w_cnt >= r_max);
        w_allowed = (r_max == '0) || !w_deny;

        w_new.used      = 1'b1;
        w_new.win_begin = w_restart ? r_b_now : w_ent.win_begin;
        w_new.count     = w_deny ? w_cnt : w_cnt + COUNT_W'(1);
    end

    // Limiting disabled leaves the table untouched.
    assign w_upd = w_b_go && (r_max != '0);

    // Sweep writes have priority; they never overlap requests in normal use.
    always_comb begin
        if (w_sweep.busy) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = w_sweep.addr;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_upd;
            w_mem_waddr = r_b_slot;
            w_mem_wdata = w_new;
        end
    end

    pcfwl_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_slot),
        .o_rdata (w_rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_accept) begin
            r_b_valid <= 1'b1;
        end else if (w_b_go) begin
            r_b_valid <= 1'b0;
        end
    end

    // Capture the request and note a write to its entry in the same cycle as its read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_slot   <= w_in_slot;
            r_b_now    <= i_req.now_time;
            r_fwd_hit  <= w_upd && (r_b_slot == w_in_slot);
            r_fwd_data <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_b_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_go) begin
            r_out_allowed <= w_allowed;
        end
    end

    assign i_req.ready   = w_ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.allowed = r_out_allowed;
endmodule
`default_nettype wire

// ===== design/pcfwl_checker.sv =====
// Port-level checker of the limiter and its bind to the top level.
`default_nettype none
`include "per_client_fixed_window_limiter_assert.svh"
module pcfwl_checker
    import pcfwl_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_cfg_we,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic                 i_req_valid,
    input wire logic                 i_req_ready,
    input wire logic                 i_rsp_valid,
    input wire logic                 i_rsp_ready,
    input wire logic                 i_rsp_allowed
);
    logic w_req_acc;
    logic w_rsp_stall;

    assign w_req_acc   = i_req_valid && i_req_ready;
    assign w_rsp_stall = i_rsp_valid && !i_rsp_ready;

    // A stalled answer stays valid and unchanged.
    `PCFWL_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, w_rsp_stall, i_rsp_valid && $stable(i_rsp_allowed))

    // Reset starts the clearing sweep, so no request is taken right after.
    `PCFWL_ASSERT_NEXT_ALWAYS(a_rst_sweep, i_clk, !i_rst_n, !i_req_ready)

    // A limit write starts a new sweep.
    `PCFWL_ASSERT_NEXT(a_cfg_sweep, i_clk, i_rst_n, i_cfg_we && (i_cfg_index == CFG_MAX_PER_WINDOW), !i_req_ready)

    // A new answer on an idle output comes only from a taken request, via the decision stage.
    `PCFWL_ASSERT_SAME(a_rsp_cause, i_clk, i_rst_n, i_rsp_valid && !$past(i_rsp_valid), $past(w_req_acc, 2))
endmodule

bind per_client_fixed_window_limiter pcfwl_checker u_pcfwl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_index   (i_cfg_index),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_allowed (o_rsp.allowed)
);
`default_nettype wire
